### hw/rtl/bpa_pkg.sv
// Shared constants, operation and status codes, and map layout functions
// for the buddy page allocator. Depends on nothing; every other file imports it.
package bpa_pkg;

    // Fixed field widths of the request and result items.
    localparam int PAGE_W  = 16;
    localparam int COUNT_W = 17;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int ORDER_W = 5;
    localparam int WORD_W  = 32;
    localparam int WORD_MASK = 31;

    // Default sizing.
    localparam int NUM_ORDERS_DEF       = 17;
    localparam int REGION_PAGES_MAX_DEF = 65536;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADARG  = 2'd2;

    // Number of blocks of a given order in the region.
    function automatic int bpa_slots(input int rpm, input int k);
        return rpm >> k;
    endfunction

    // Number of map words that hold the bits of one order.
    function automatic int bpa_words(input int rpm, input int k);
        return (bpa_slots(rpm, k) + WORD_MASK) >> 5;
    endfunction

    // First map word of an order; the orders are stored one after another.
    function automatic int bpa_base(input int rpm, input int k);
        int sum;
        sum = 0;
        for (int i = 0; i < k; i++)
        begin
            sum = sum + bpa_words(rpm, i);
        end
        return sum;
    endfunction

endpackage

### hw/rtl/bpa_map_ram.sv
// Free map storage: simple dual-port RAM with one write and one registered read.
// Depends on bpa_pkg for the word width.
module bpa_map_ram #(
    parameter int DEPTH = 4100,
    parameter int AW    = 13
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [bpa_pkg::WORD_W-1:0] rd_data,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [bpa_pkg::WORD_W-1:0] wr_data
);
    import bpa_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/buddy_page_allocator_top.sv
// Buddy page allocator top level: request decode, map sequencer and result register.
// Depends on bpa_pkg and bpa_map_ram.
//
// The allocator keeps one free bit per block per order in a single word-wide RAM
// and serves one request at a time; each request returns exactly one result.
// After reset, and at the start of every initialise request, a clearing pass
// writes every map word once (bpa_base(REGION_PAGES_MAX, NUM_ORDERS) words,
// 4100 at the defaults) and accepts no request meanwhile; configuration writes
// are taken at any time. Initialise then carves the region block by block.
// Allocate scans the map words of each order from the rounded order upward,
// reading and then checking each word, then splits one level at a time; at
// the defaults a worst-case scan of order 0 touches 2048 words. Free merges
// upward level by level, then sets the freed block's bit. Map RAM reads are
// registered, so each step reads a word and then writes it back.
module buddy_page_allocator_top #(
    parameter int NUM_ORDERS       = bpa_pkg::NUM_ORDERS_DEF,
    parameter int REGION_PAGES_MAX = bpa_pkg::REGION_PAGES_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: region_pages.
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [15:0] page_index, [32:16] request_pages, zero fill
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] block_index, [20:16] block_order, zero fill
    output logic [1:0]  m_tuser    // [1:0] status
);
    import bpa_pkg::*;

    localparam int TOTAL     = bpa_base(REGION_PAGES_MAX, NUM_ORDERS);
    localparam int AW        = $clog2(TOTAL);
    localparam int MAP_WORDS = bpa_words(REGION_PAGES_MAX, 0);
    localparam int WW        = $clog2(MAP_WORDS + 1);
    localparam int OFF_W     = $clog2(REGION_PAGES_MAX + 1);
    localparam int OW        = $clog2(NUM_ORDERS);
    localparam int TOP       = NUM_ORDERS - 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CARVE, S_CARVE_WR, S_SCAN_RD, S_SCAN_CHK,
        S_SPLIT_RD, S_SPLIT_WR, S_FREE_CHK, S_FREE_MRG, S_FREE_SET,
        S_FREE_WR, S_DONE
    } state_t;

    state_t               state_reg;
    logic [COUNT_W-1:0]   region_reg;
    logic [AW-1:0]        clr_reg;
    logic                 clr_init_reg;
    logic [OFF_W-1:0]     n_reg;
    logic [OFF_W-1:0]     off_reg;
    logic [OW-1:0]        j_reg;
    logic [OW-1:0]        k_reg;
    logic [OFF_W-1:0]     b_reg;
    logic [WW-1:0]        w_reg;
    logic [STAT_W-1:0]    res_status_reg;
    logic [PAGE_W-1:0]    res_index_reg;
    logic [ORDER_W-1:0]   res_order_reg;
    logic                 m_tvalid_reg;
    logic [STAT_W-1:0]    out_status_reg;
    logic [PAGE_W-1:0]    out_index_reg;
    logic [ORDER_W-1:0]   out_order_reg;

    // Map layout tables; these fold to constants.
    logic [AW-1:0]    base_tbl  [NUM_ORDERS];
    logic [WW-1:0]    words_tbl [NUM_ORDERS];
    logic [OFF_W-1:0] slots_tbl [NUM_ORDERS];

    always_comb
    begin
        for (int i = 0; i < NUM_ORDERS; i++)
        begin
            base_tbl[i]  = AW'(bpa_base(REGION_PAGES_MAX, i));
            words_tbl[i] = WW'(bpa_words(REGION_PAGES_MAX, i));
            slots_tbl[i] = OFF_W'(bpa_slots(REGION_PAGES_MAX, i));
        end
    end

    // RAM connection.
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;

    bpa_map_ram #(
        .DEPTH (TOTAL),
        .AW    (AW)
    ) u_map (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Request field unpacking.
    logic [OP_W-1:0]    op_in;
    logic [PAGE_W-1:0]  page_in;
    logic [COUNT_W-1:0] req_in;

    assign op_in   = s_tuser;
    assign page_in = s_tdata[15:0];
    assign req_in  = s_tdata[32:16];

    // Rounded order of the requested count.
    logic          req_ok;
    logic [OW-1:0] k_req;

    always_comb
    begin
        req_ok = 1'b0;
        k_req  = '0;
        for (int i = NUM_ORDERS - 1; i >= 0; i--)
        begin
            if ((64'd1 << i) >= 64'(req_in))
            begin
                req_ok = 1'b1;
                k_req  = OW'(i);
            end
        end
        if (req_in == '0)
        begin
            req_ok = 1'b0;
        end
    end

    // End of the block being freed, one past its last page.
    logic [31:0] free_end;
    assign free_end = ((32'(page_in) >> k_req) << k_req) + (32'd1 << k_req);

    // Largest block order that fits the remaining region while carving.
    logic [OW-1:0] j_carve;

    always_comb
    begin
        int hb;
        hb = 0;
        for (int i = 0; i < OFF_W; i++)
        begin
            if (n_reg[i])
            begin
                hb = i;
            end
        end
        if (hb > TOP)
        begin
            hb = TOP;
        end
        j_carve = OW'(hb);
    end

    // Address and bit masks for the current block and its buddy.
    logic [31:0]       bw;
    logic [31:0]       bud_w;
    logic [31:0]       b_dn;
    logic [31:0]       b_carve;
    logic [OW-1:0]     j_dn;
    logic [AW-1:0]     addr_b;
    logic [AW-1:0]     addr_bud;
    logic [AW-1:0]     addr_scan;
    logic [AW-1:0]     addr_split;
    logic [AW-1:0]     addr_carve;
    logic [WORD_W-1:0] mask_b;
    logic [WORD_W-1:0] mask_bud;
    logic              bud_ok;

    assign bw         = 32'(b_reg);
    assign bud_w      = bw ^ 32'd1;
    assign j_dn       = j_reg - 1'b1;
    assign b_dn       = bw << 1;
    assign b_carve    = 32'(off_reg) >> j_carve;
    assign addr_b     = AW'(32'(base_tbl[j_reg]) + (bw >> 5));
    assign addr_bud   = AW'(32'(base_tbl[j_reg]) + (bud_w >> 5));
    assign addr_scan  = AW'(32'(base_tbl[j_reg]) + 32'(w_reg));
    assign addr_split = AW'(32'(base_tbl[j_dn]) + (b_dn >> 5));
    assign addr_carve = AW'(32'(base_tbl[j_carve]) + (b_carve >> 5));
    assign mask_b     = WORD_W'(1) << bw[4:0];
    assign mask_bud   = WORD_W'(1) << bud_w[4:0];
    assign bud_ok     = (j_reg != OW'(TOP)) && (bud_w < 32'(slots_tbl[j_reg]));

    // Lowest set bit of the word just read.
    logic [4:0]        lsb;
    logic [WORD_W-1:0] lsb_mask;

    always_comb
    begin
        lsb = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (rd_data[i])
            begin
                lsb = 5'(i);
            end
        end
        lsb_mask = WORD_W'(1) << lsb;
    end

    // Map RAM access for each sequencer step.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = addr_b;
        wr_en   = 1'b0;
        wr_addr = addr_b;
        wr_data = rd_data | mask_b;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
            end
            S_CARVE:
            begin
                rd_en   = (n_reg != '0);
                rd_addr = addr_carve;
            end
            S_CARVE_WR, S_SPLIT_WR, S_FREE_WR:
            begin
                wr_en = 1'b1;
            end
            S_SCAN_RD:
            begin
                rd_en   = (w_reg < words_tbl[j_reg]);
                rd_addr = addr_scan;
            end
            S_SCAN_CHK:
            begin
                wr_en   = (rd_data != '0);
                wr_addr = addr_scan;
                wr_data = rd_data & ~lsb_mask;
            end
            S_SPLIT_RD:
            begin
                rd_en   = (j_reg != k_reg);
                rd_addr = addr_split;
            end
            S_FREE_CHK:
            begin
                rd_en   = bud_ok;
                rd_addr = addr_bud;
            end
            S_FREE_MRG:
            begin
                wr_en   = ((rd_data & mask_bud) != '0);
                wr_addr = addr_bud;
                wr_data = rd_data & ~mask_bud;
            end
            S_FREE_SET:
            begin
                rd_en = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg <= '0;
        end
        else if (cfg_we)
        begin
            region_reg <= cfg_wdata;
        end
    end

    // Sequencer and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            clr_init_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            n_reg          <= '0;
            off_reg        <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            b_reg          <= '0;
            w_reg          <= '0;
            res_status_reg <= ST_OK;
            res_index_reg  <= '0;
            res_order_reg  <= '0;
            out_status_reg <= ST_OK;
            out_index_reg  <= '0;
            out_order_reg  <= '0;
        end
        else
        begin
            // The done step reloads the output register itself.
            if (m_tvalid_reg && m_tready && state_reg != S_DONE)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                // Sweep every map word to zero.
                S_CLEAR:
                begin
                    if (clr_reg == AW'(TOTAL - 1))
                    begin
                        clr_reg      <= '0;
                        clr_init_reg <= 1'b0;
                        state_reg    <= clr_init_reg ? S_CARVE : S_IDLE;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + 1'b1;
                    end
                end

                // Decode a new request.
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        res_index_reg <= '0;
                        case (op_in)
                            OP_INIT:
                            begin
                                if (32'(region_reg) > 32'(REGION_PAGES_MAX))
                                begin
                                    n_reg <= OFF_W'(REGION_PAGES_MAX);
                                end
                                else
                                begin
                                    n_reg <= OFF_W'(region_reg);
                                end
                                off_reg        <= '0;
                                clr_reg        <= '0;
                                clr_init_reg   <= 1'b1;
                                res_status_reg <= ST_OK;
                                res_order_reg  <= '0;
                                state_reg      <= S_CLEAR;
                            end
                            OP_ALLOC:
                            begin
                                if (!req_ok)
                                begin
                                    res_status_reg <= ST_BADARG;
                                    res_order_reg  <= '0;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    res_status_reg <= ST_OK;
                                    k_reg          <= k_req;
                                    j_reg          <= k_req;
                                    w_reg          <= '0;
                                    res_order_reg  <= ORDER_W'(k_req);
                                    state_reg      <= S_SCAN_RD;
                                end
                            end
                            OP_FREE:
                            begin
                                if (!req_ok || free_end > 32'(REGION_PAGES_MAX))
                                begin
                                    res_status_reg <= ST_BADARG;
                                    res_order_reg  <= '0;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    res_status_reg <= ST_OK;
                                    k_reg          <= k_req;
                                    j_reg          <= k_req;
                                    b_reg          <= OFF_W'(32'(page_in) >> k_req);
                                    res_order_reg  <= ORDER_W'(k_req);
                                    state_reg      <= S_FREE_CHK;
                                end
                            end
                            default:
                            begin
                                res_status_reg <= ST_OK;
                                res_order_reg  <= '0;
                                state_reg      <= S_DONE;
                            end
                        endcase
                    end
                end

                // Carve the region into descending aligned blocks.
                S_CARVE:
                begin
                    if (n_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        j_reg     <= j_carve;
                        b_reg     <= OFF_W'(b_carve);
                        state_reg <= S_CARVE_WR;
                    end
                end

                S_CARVE_WR:
                begin
                    off_reg   <= off_reg + OFF_W'(32'd1 << j_reg);
                    n_reg     <= n_reg - OFF_W'(32'd1 << j_reg);
                    state_reg <= S_CARVE;
                end

                // Scan the words of the current order for a free block.
                S_SCAN_RD:
                begin
                    if (w_reg >= words_tbl[j_reg])
                    begin
                        if (j_reg == OW'(TOP))
                        begin
                            res_status_reg <= ST_NOSPACE;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            j_reg <= j_reg + 1'b1;
                            w_reg <= '0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CHK;
                    end
                end

                S_SCAN_CHK:
                begin
                    if (rd_data != '0)
                    begin
                        b_reg     <= OFF_W'((32'(w_reg) << 5) | 32'(lsb));
                        state_reg <= S_SPLIT_RD;
                    end
                    else
                    begin
                        w_reg     <= w_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end

                // Split down to the requested order, freeing each lower half.
                S_SPLIT_RD:
                begin
                    if (j_reg == k_reg)
                    begin
                        res_index_reg <= PAGE_W'(bw << k_reg);
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        j_reg     <= j_dn;
                        b_reg     <= OFF_W'(b_dn);
                        state_reg <= S_SPLIT_WR;
                    end
                end

                S_SPLIT_WR:
                begin
                    b_reg     <= b_reg | OFF_W'(1);
                    state_reg <= S_SPLIT_RD;
                end

                // Merge upward while the buddy is free.
                S_FREE_CHK:
                begin
                    state_reg <= bud_ok ? S_FREE_MRG : S_FREE_SET;
                end

                S_FREE_MRG:
                begin
                    if ((rd_data & mask_bud) != '0)
                    begin
                        b_reg     <= b_reg >> 1;
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_FREE_CHK;
                    end
                    else
                    begin
                        state_reg <= S_FREE_SET;
                    end
                end

                S_FREE_SET:
                begin
                    state_reg <= S_FREE_WR;
                end

                S_FREE_WR:
                begin
                    state_reg <= S_DONE;
                end

                // Hand the result to the output register once it is free.
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_index_reg  <= res_index_reg;
                        out_order_reg  <= res_order_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Port drive.
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_order_reg, out_index_reg};

endmodule

### sim/testbench.sv
// Testbench for the buddy page allocator: directed table, then random phases.
// Depends on bpa_pkg and buddy_page_allocator_top; every result is checked in order.
`timescale 1ns / 1ps

module testbench;

    import bpa_pkg::*;

    localparam int NORD      = NUM_ORDERS_DEF;
    localparam int TOP       = NORD - 1;
    localparam int PAGES_MAX = REGION_PAGES_MAX_DEF;
    localparam int STALL_LIMIT = 200000;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [PAGE_W-1:0]  index;
        logic [ORDER_W-1:0] order;
    } answer_t;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [PAGE_W-1:0]  page;
        logic [COUNT_W-1:0] count;
        bit                 typed;
        answer_t            ans;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [16:0]        cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [39:0]        s_tdata;
    logic [1:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [23:0]        m_tdata;
    logic [1:0]         m_tuser;

    // Predictor state: per-order sets of free block numbers.
    bit        free_blocks [NORD][int];
    int        region_cfg;
    answer_t   pending_answers[$];
    int        errors = 0;
    bit        idle_on;
    int        n_alloc_ok, n_alloc_full, n_free, n_other;

    // Blocks handed out and not yet returned.
    int        held_index[$];
    int        held_order[$];

    buddy_page_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int rounded_order(input int count);
        for (int k = 0; k < NORD; k++)
        begin
            if ((1 << k) >= count && count > 0)
            begin
                return k;
            end
        end
        return -1;
    endfunction

    function automatic void mark_free(input int k, input int b, input bit v);
        if (b < (PAGES_MAX >> k))
        begin
            if (v)
            begin
                free_blocks[k][b] = 1'b1;
            end
            else if (free_blocks[k].exists(b))
            begin
                free_blocks[k].delete(b);
            end
        end
    endfunction

    // Applies one request to the allocator state and returns its answer.
    function automatic answer_t allocator_answer(input logic [OP_W-1:0] op,
                                                 input int page, input int count);
        answer_t a;
        int      k, j, b, n, off, e;
        bit      found;
        a = '0;
        if (op == OP_INIT)
        begin
            for (int i = 0; i < NORD; i++)
            begin
                free_blocks[i].delete();
            end
            n = (region_cfg > PAGES_MAX) ? PAGES_MAX : region_cfg;
            off = 0;
            while (n > 0)
            begin
                j = 0;
                while (j < TOP && (2 << j) <= n)
                begin
                    j++;
                end
                mark_free(j, off >> j, 1'b1);
                off += 1 << j;
                n -= 1 << j;
            end
        end
        else if (op == OP_ALLOC || op == OP_FREE)
        begin
            k = rounded_order(count);
            if (k < 0)
            begin
                a.status = ST_BADARG;
            end
            else if (op == OP_ALLOC)
            begin
                a.order = ORDER_W'(k);
                found = 1'b0;
                for (j = k; j < NORD; j++)
                begin
                    if (free_blocks[j].first(b))
                    begin
                        found = 1'b1;
                        break;
                    end
                end
                if (!found)
                begin
                    a.status = ST_NOSPACE;
                end
                else
                begin
                    // Split downward: the lower half stays free, the upper half goes on.
                    mark_free(j, b, 1'b0);
                    while (j > k)
                    begin
                        j--;
                        b = b << 1;
                        mark_free(j, b, 1'b1);
                        b = b | 1;
                    end
                    a.index = PAGE_W'(b << k);
                end
            end
            else
            begin
                j = k;
                b = page >> j;
                e = (b << j) + (1 << j);
                if (e > PAGES_MAX)
                begin
                    a.status = ST_BADARG;
                end
                else
                begin
                    a.order = ORDER_W'(k);
                    // Merge with the buddy while it is free, below the top order.
                    while (j < TOP && free_blocks[j].exists(b ^ 1))
                    begin
                        mark_free(j, b ^ 1, 1'b0);
                        b = b >> 1;
                        j++;
                    end
                    mark_free(j, b, 1'b1);
                end
            end
        end
        return a;
    endfunction

    // Drives one request, optionally idling first, and records its answer on acceptance.
    task automatic send_request(input logic [OP_W-1:0] op, input int page, input int count,
                                input bit typed, input answer_t typed_ans);
        int      gap;
        answer_t a;
        gap = 0;
        while (idle_on && $urandom_range(99) < 33)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, count[16:0], page[15:0]};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        a = allocator_answer(op, page, count);
        if (op == OP_ALLOC && a.status == ST_OK)
        begin
            held_index.push_back(a.index);
            held_order.push_back(a.order);
            n_alloc_ok++;
        end
        else if (op == OP_ALLOC && a.status == ST_NOSPACE)
        begin
            n_alloc_full++;
        end
        else if (op == OP_FREE)
        begin
            n_free++;
        end
        else
        begin
            n_other++;
        end
        pending_answers.push_back(typed ? typed_ans : a);
    endtask

    // Lets every outstanding answer arrive, then a short settle.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_region(input int v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[16:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        region_cfg = v & 32'h1FFFF;
    endtask

    // Result checking and the stall watchdog.
    int stall_count;
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d index=%0d order=%0d",
                             $time, m_tuser, m_tdata[15:0], m_tdata[20:16]);
                    errors++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[15:0] !== want.index)
                    begin
                        $display("%0t: block_index expected %0d actual %0d",
                                 $time, want.index, m_tdata[15:0]);
                        errors++;
                    end
                    if (m_tdata[20:16] !== want.order)
                    begin
                        $display("%0t: block_order expected %0d actual %0d",
                                 $time, want.order, m_tdata[20:16]);
                        errors++;
                    end
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
            begin
                stall_count <= 0;
            end
            else
            begin
                stall_count <= stall_count + 1;
                if (stall_count >= STALL_LIMIT)
                begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
        else
        begin
            stall_count <= 0;
        end
        m_tready <= idle_on ? ($urandom_range(99) >= 33) : 1'b1;
    end

    row_t    table_rows[$];
    answer_t zero_ans;

    function automatic row_t mk_row(input logic [OP_W-1:0] op, input int page, input int count,
                                    input bit typed, input logic [STAT_W-1:0] st,
                                    input int idx, input int ord);
        row_t r;
        r.op = op;
        r.page = PAGE_W'(page);
        r.count = COUNT_W'(count);
        r.typed = typed;
        r.ans.status = st;
        r.ans.index = PAGE_W'(idx);
        r.ans.order = ORDER_W'(ord);
        return r;
    endfunction

    initial
    begin
        int regions[8];
        int k, count, page, pick, op;
        regions = '{65536, 1, 131071, 0, 65535, 3000, 77, 40000};
        region_cfg = 0;
        idle_on = 1'b1;
        zero_ans = '0;
        n_alloc_ok = 0; n_alloc_full = 0; n_free = 0; n_other = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: reset state, extremes, error codes, merging and misaligned frees.
        table_rows.push_back(mk_row(OP_ALLOC, 0, 1, 1, ST_NOSPACE, 0, 0));
        table_rows.push_back(mk_row(OP_NONE, 16'hFFFF, 17'h1FFFF, 1, ST_OK, 0, 0));
        table_rows.push_back(mk_row(OP_INIT, 0, 0, 1, ST_OK, 0, 0));
        table_rows.push_back(mk_row(OP_ALLOC, 0, 0, 1, ST_BADARG, 0, 0));
        table_rows.push_back(mk_row(OP_ALLOC, 0, 65537, 1, ST_BADARG, 0, 0));
        table_rows.push_back(mk_row(OP_FREE, 16'hFFFF, 17'h1FFFF, 1, ST_BADARG, 0, 0));
        table_rows.push_back(mk_row(OP_ALLOC, 0, 65536, 1, ST_OK, 0, 16));
        table_rows.push_back(mk_row(OP_ALLOC, 0, 1, 1, ST_NOSPACE, 0, 0));
        table_rows.push_back(mk_row(OP_FREE, 0, 65536, 1, ST_OK, 0, 16));
        table_rows.push_back(mk_row(OP_ALLOC, 0, 1, 0, ST_OK, 0, 0));
        table_rows.push_back(mk_row(OP_ALLOC, 0, 3, 0, ST_OK, 0, 0));
        table_rows.push_back(mk_row(OP_ALLOC, 0, 32768, 0, ST_OK, 0, 0));
        table_rows.push_back(mk_row(OP_FREE, 16'hFFFF, 1, 0, ST_OK, 0, 0));
        table_rows.push_back(mk_row(OP_FREE, 16'hFFFD, 2, 0, ST_OK, 0, 0));
        table_rows.push_back(mk_row(OP_FREE, 16'hFFFF, 1, 0, ST_OK, 0, 0));
        table_rows.push_back(mk_row(OP_FREE, 16'h8000, 32768, 0, ST_OK, 0, 0));
        table_rows.push_back(mk_row(OP_ALLOC, 0, 5, 0, ST_OK, 0, 0));
        table_rows.push_back(mk_row(OP_ALLOC, 0, 1, 0, ST_OK, 0, 0));
        table_rows.push_back(mk_row(OP_ALLOC, 0, 65536, 0, ST_OK, 0, 0));

        write_region(65536);
        foreach (table_rows[i])
        begin
            send_request(table_rows[i].op, table_rows[i].page, table_rows[i].count,
                         table_rows[i].typed, table_rows[i].ans);
        end
        drain();
        held_index.delete();
        held_order.delete();

        // Random phases, each with its own region size and a fresh initialise.
        for (int ph = 0; ph < 8; ph++)
        begin
            idle_on = (ph != 3);
            write_region((ph == 7) ? $urandom_range(131071) : regions[ph]);
            send_request(OP_INIT, $urandom_range(65535), $urandom_range(131071), 0, zero_ans);
            held_index.delete();
            held_order.delete();
            for (int n = 0; n < 180; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 45 || (pick < 85 && held_index.size() == 0))
                begin
                    k = ($urandom_range(9) == 0) ? $urandom_range(16) : $urandom_range(5);
                    count = (k == 0) ? 1 : $urandom_range((1 << k), (1 << (k - 1)) + 1);
                    send_request(OP_ALLOC, $urandom_range(65535), count, 0, zero_ans);
                end
                else if (pick < 85)
                begin
                    // Return a held block; some frees use a misaligned offset.
                    k = $urandom_range(held_index.size() - 1);
                    page = held_index[k];
                    if ($urandom_range(4) == 0)
                    begin
                        page = page | $urandom_range((1 << held_order[k]) - 1);
                    end
                    count = (held_order[k] == 0) ? 1 :
                            $urandom_range((1 << held_order[k]), (1 << (held_order[k] - 1)) + 1);
                    held_index.delete(k);
                    held_order.delete(k);
                    send_request(OP_FREE, page, count, 0, zero_ans);
                end
                else
                begin
                    op = $urandom_range(3);
                    if (op == OP_INIT)
                    begin
                        op = OP_NONE;
                    end
                    send_request(OP_W'(op), $urandom_range(65535), $urandom_range(131071),
                                 0, zero_ans);
                end
            end
            drain();
        end

        $display("covered %0d good allocations, %0d full allocations, %0d frees, %0d other",
                 n_alloc_ok, n_alloc_full, n_free, n_other);
        $display("over eight region sizes including zero, one, full and oversized");
        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
